// ===== rtl/multi_queue_engine_assert.svh =====
// assertion helpers for the queue engine
`ifndef MULTI_QUEUE_ENGINE_ASSERT_SVH
`define MULTI_QUEUE_ENGINE_ASSERT_SVH

// same-cycle implication
`define MQE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue engine assertion failed");

// next-cycle implication
`define MQE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue engine assertion failed");

`endif

// ===== rtl/mqe_pkg.sv =====
package mqe_pkg;

  localparam int QNUM_BITS    = 4;
  localparam int CFG_BITS     = 4;
  localparam int OUTCOME_BITS = 3;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

  // result queue
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_BITS = 2;
  localparam int OQ_CNT_BITS = 3;

  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [OUTCOME_BITS-1:0] {
    OUT_ENQUEUED = 3'd0,
    OUT_DEQUEUED = 3'd1,
    OUT_INVALID  = 3'd2,
    OUT_EMPTY    = 3'd3,
    OUT_FULL     = 3'd4
  } outcome_t;

endpackage

// ===== rtl/mqe_in_if.sv =====
interface mqe_in_if #(
  parameter int TAG_BITS = 16
);
  logic                             valid;
  logic                             ready;
  mqe_pkg::op_t                     op;
  logic [mqe_pkg::QNUM_BITS-1:0]    queue_number;
  logic [TAG_BITS-1:0]              item_tag;

  modport source (output valid, output op, output queue_number, output item_tag,
                  input ready);
  modport sink   (input valid, input op, input queue_number, input item_tag,
                  output ready);
endinterface

// ===== rtl/mqe_out_if.sv =====
interface mqe_out_if #(
  parameter int TAG_BITS = 16
);
  logic                 valid;
  logic                 ready;
  mqe_pkg::outcome_t    outcome;
  logic [TAG_BITS-1:0]  out_tag;

  modport source (output valid, output outcome, output out_tag, input ready);
  modport sink   (input valid, input outcome, input out_tag, output ready);
endinterface

// ===== rtl/mqe_ram.sv =====
module mqe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/multi_queue_engine.sv =====
// A result is offered once its transaction has passed the stage 1 and stage 2 registers and is in the output queue.
// Throughput: one transaction per cycle while results are taken; the pointer table
// read, the forwarding of the previous pointer write and the tag memory port set this.
// cmd.ready drops once four transactions are in flight or waiting at the output.
// Reset (rst, synchronous): all queues empty, queues_in_use = 8, output queue empty.
// Tag storage is not cleared; a tag is only read after it was written.
`include "multi_queue_engine_assert.svh"

module multi_queue_engine #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [mqe_pkg::CFG_BITS-1:0]   cfg_wr_data,
  mqe_in_if.sink                         cmd,
  mqe_out_if.source                      res
);

  import mqe_pkg::*;

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = HW + 1;
  localparam int PW = HW + CW;
  localparam int ID = NUM_QUEUES * QUEUE_DEPTH;
  localparam int IW = $clog2(ID);
  localparam int LW = QNUM_BITS + 1;

  // configuration
  logic [CFG_BITS-1:0] queues_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      queues_in_use <= CFG_RESET;
    end else if (cfg_wr_en) begin
      queues_in_use <= cfg_wr_data;
    end
  end

  // input decode
  logic [LW-1:0]        limit;
  logic                 cmd_ok;
  logic [QNUM_BITS-1:0] cmd_qidx;
  logic [QW-1:0]        cmd_q;
  logic                 accept;

  assign limit    = (LW'(queues_in_use) > LW'(NUM_QUEUES)) ? LW'(NUM_QUEUES)
                                                          : LW'(queues_in_use);
  assign cmd_ok   = (cmd.queue_number != '0) && (LW'(cmd.queue_number) <= limit);
  assign cmd_qidx = cmd.queue_number - QNUM_BITS'(1);
  assign cmd_q    = cmd_qidx[QW-1:0];
  assign accept   = cmd.valid && cmd.ready;

  // pointer table: {head, count} per queue
  logic                  ptr_we;
  logic [PW-1:0]         ptr_wdata;
  logic [PW-1:0]         ptr_rd;
  logic [NUM_QUEUES-1:0] ptr_valid;

  // stage 1
  logic          s1_v;
  op_t           s1_op;
  logic          s1_ok;
  logic [QW-1:0] s1_q;
  logic [TAG_BITS-1:0] s1_tag;
  logic          s1_pv;

  // last pointer write, for forwarding
  logic          lw_v;
  logic [QW-1:0] lw_q;
  logic [PW-1:0] lw_data;

  // stage 2
  logic     s2_v;
  outcome_t s2_outcome;

  // output queue
  outcome_t            oq_outcome [OQ_DEPTH];
  logic [TAG_BITS-1:0] oq_tag     [OQ_DEPTH];
  logic [OQ_PTR_BITS-1:0] oq_wr;
  logic [OQ_PTR_BITS-1:0] oq_rd;
  logic [OQ_CNT_BITS-1:0] oq_count;
  logic [OQ_CNT_BITS-1:0] credit;
  logic                   push;
  logic                   pop;

  assign credit    = oq_count + OQ_CNT_BITS'(s1_v) + OQ_CNT_BITS'(s2_v);
  assign cmd.ready = credit < OQ_CNT_BITS'(OQ_DEPTH);

  mqe_ram #(
    .WIDTH (PW),
    .DEPTH (NUM_QUEUES)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (s1_q),
    .wdata (ptr_wdata),
    .re    (accept),
    .raddr (cmd_q),
    .rdata (ptr_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_valid <= '0;
      s1_v      <= 1'b0;
      lw_v      <= 1'b0;
      s2_v      <= 1'b0;
    end else begin
      if (ptr_we) begin
        ptr_valid[s1_q] <= 1'b1;
      end
      s1_v <= accept;
      lw_v <= ptr_we;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op  <= cmd.op;
      s1_ok  <= cmd_ok;
      s1_q   <= cmd_q;
      s1_tag <= cmd.item_tag;
      s1_pv  <= ptr_valid[cmd_q];
    end
    lw_q    <= s1_q;
    lw_data <= ptr_wdata;
  end

  // stage 1: read-modify-write of the pointers
  logic [PW-1:0] ptr_cur;
  logic [HW-1:0] head;
  logic [CW-1:0] count;
  logic [SW-1:0] sum;
  logic [HW-1:0] slot_enq;
  logic [HW-1:0] head_inc;
  logic [HW-1:0] slot;
  logic          full;
  logic          empty;
  logic          item_we;
  logic          item_re;
  logic [IW-1:0] item_addr;
  logic [TAG_BITS-1:0] item_rd;
  outcome_t      outcome;

  assign ptr_cur  = (lw_v && (lw_q == s1_q)) ? lw_data : (s1_pv ? ptr_rd : '0);
  assign head     = ptr_cur[PW-1:CW];
  assign count    = ptr_cur[CW-1:0];
  assign sum      = SW'(head) + SW'(count);
  assign slot_enq = (sum >= SW'(QUEUE_DEPTH)) ? HW'(sum - SW'(QUEUE_DEPTH)) : HW'(sum);
  assign head_inc = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + HW'(1);
  assign full     = count == CW'(QUEUE_DEPTH);
  assign empty    = count == '0;

  always_comb begin
    ptr_we    = 1'b0;
    ptr_wdata = ptr_cur;
    item_we   = 1'b0;
    item_re   = 1'b0;
    slot      = head;
    outcome   = OUT_INVALID;
    if (s1_v && s1_ok) begin
      if (s1_op == OP_ENQUEUE) begin
        if (full) begin
          outcome = OUT_FULL;
        end else begin
          outcome   = OUT_ENQUEUED;
          ptr_we    = 1'b1;
          item_we   = 1'b1;
          slot      = slot_enq;
          ptr_wdata = {head, count + CW'(1)};
        end
      end else begin
        if (empty) begin
          outcome = OUT_EMPTY;
        end else begin
          outcome   = OUT_DEQUEUED;
          ptr_we    = 1'b1;
          item_re   = 1'b1;
          ptr_wdata = {head_inc, count - CW'(1)};
        end
      end
    end
  end

  assign item_addr = IW'(s1_q) * IW'(QUEUE_DEPTH) + IW'(slot);

  mqe_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (ID)
  ) u_item_ram (
    .clk   (clk),
    .we    (item_we),
    .waddr (item_addr),
    .wdata (s1_tag),
    .re    (item_re),
    .raddr (item_addr),
    .rdata (item_rd)
  );

  always_ff @(posedge clk) begin
    s2_outcome <= outcome;
  end

  // output queue
  assign push      = s2_v;
  assign pop       = res.valid && res.ready;
  assign res.valid = oq_count != '0;
  assign res.outcome = oq_outcome[oq_rd];
  assign res.out_tag = oq_tag[oq_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (push) begin
        oq_wr <= oq_wr + OQ_PTR_BITS'(1);
      end
      if (pop) begin
        oq_rd <= oq_rd + OQ_PTR_BITS'(1);
      end
      oq_count <= oq_count + OQ_CNT_BITS'(push) - OQ_CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq_outcome[oq_wr] <= s2_outcome;
      oq_tag[oq_wr]     <= (s2_outcome == OUT_DEQUEUED) ? item_rd : '0;
    end
  end

  `MQE_ASSERT_IMPL(a_credit_bound, clk, rst, 1'b1, credit <= OQ_CNT_BITS'(OQ_DEPTH))
  `MQE_ASSERT_NEXT(a_no_drop, clk, rst, s1_v, s2_v)
  `MQE_ASSERT_IMPL(a_deq_read, clk, rst, s2_v && (s2_outcome == OUT_DEQUEUED), $past(item_re))
  `MQE_ASSERT_IMPL(a_count_range, clk, rst, ptr_we, ptr_wdata[CW-1:0] <= CW'(QUEUE_DEPTH))

endmodule

// ===== bench/tb_multi_queue_engine.sv =====
module tb_multi_queue_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import mqe_pkg::*;

  localparam int NQ         = 8;
  localparam int DEPTH      = 16;
  localparam int TAGW       = 16;
  localparam int CYCLE_CAP  = 300000;
  localparam int HOLD_LEN   = 60;

  typedef struct {
    op_t                    op;
    logic [QNUM_BITS-1:0]   qn;
    logic [TAGW-1:0]        tag;
  } cmd_item_t;

  typedef struct {
    outcome_t               outcome;
    logic [TAGW-1:0]        tag;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_BITS-1:0]  cfg_wr_data;

  mqe_in_if  #(.TAG_BITS(TAGW)) cmd_if ();
  mqe_out_if #(.TAG_BITS(TAGW)) res_if ();

  multi_queue_engine #(
    .NUM_QUEUES  (NQ),
    .QUEUE_DEPTH (DEPTH),
    .TAG_BITS    (TAGW)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_if),
    .res         (res_if)
  );

  always #5 clk = ~clk;

  // mirror of the queue bank
  logic [CFG_BITS-1:0]  queues_cfg = CFG_RESET;
  logic [TAGW-1:0]      tag_mem [NQ][DEPTH];
  int                   head_pos [NQ];
  int                   fill_level [NQ];

  cmd_item_t            cmd_backlog [$];
  result_t              due_results [$];

  int                   burst_left;
  int                   gap_left;
  int                   hold_left;
  int                   rx_cycles;
  int                   cycle_count;
  int                   cmds_taken;
  int                   results_seen;
  int                   fail_count;
  int                   outcome_hits [5];

  function automatic result_t apply_queue_op(op_t op, logic [QNUM_BITS-1:0] qn,
                                             logic [TAGW-1:0] tag);
    result_t r;
    int      lim;
    int      q;
    int      slot;
    r.outcome = OUT_INVALID;
    r.tag     = '0;
    lim = (queues_cfg > NQ) ? NQ : queues_cfg;
    if (qn == 0 || qn > lim) return r;
    q = qn - 1;
    if (op == OP_ENQUEUE) begin
      if (fill_level[q] >= DEPTH) begin
        r.outcome = OUT_FULL;
      end else begin
        slot = (head_pos[q] + fill_level[q]) % DEPTH;
        tag_mem[q][slot] = tag;
        fill_level[q]++;
        r.outcome = OUT_ENQUEUED;
      end
    end else if (fill_level[q] == 0) begin
      r.outcome = OUT_EMPTY;
    end else begin
      r.tag = tag_mem[q][head_pos[q]];
      head_pos[q] = (head_pos[q] + 1) % DEPTH;
      fill_level[q]--;
      r.outcome = OUT_DEQUEUED;
    end
    return r;
  endfunction

  task automatic add_cmd(op_t op, int qn, int tag);
    cmd_item_t it;
    it.op  = op;
    it.qn  = QNUM_BITS'(qn);
    it.tag = TAGW'(tag);
    cmd_backlog.push_back(it);
  endtask

  // mostly runs on one queue with a fill or drain bias, plus some noise
  task automatic queue_up_random(int n);
    cmd_item_t it;
    int        focus;
    int        enq_pct;
    int        lim;
    lim = (queues_cfg > NQ) ? NQ : queues_cfg;
    focus = 1;
    enq_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        focus = (lim == 0) ? 1 : $urandom_range(1, lim);
        case ($urandom_range(0, 2))
          0: enq_pct = 25;
          1: enq_pct = 50;
          default: enq_pct = 85;
        endcase
      end
      it.tag = TAGW'($urandom_range(0, 16'hFFFF));
      if ($urandom_range(0, 99) < 8) begin
        it.qn = QNUM_BITS'($urandom_range(0, 15));
        it.op = op_t'($urandom_range(0, 1));
      end else begin
        it.qn = QNUM_BITS'(focus);
        it.op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
      end
      cmd_backlog.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || cmd_if.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_queue_limit(int v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_BITS'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    queues_cfg = CFG_BITS'(v);
  endtask

  // command driver
  always @(posedge clk) begin
    cmd_item_t nxt;
    if (rst) begin
      cmd_if.valid        <= 1'b0;
      cmd_if.op           <= OP_ENQUEUE;
      cmd_if.queue_number <= '0;
      cmd_if.item_tag     <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        due_results.push_back(apply_queue_op(cmd_if.op, cmd_if.queue_number,
                                             cmd_if.item_tag));
        cmds_taken++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_if.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          nxt = cmd_backlog.pop_front();
          cmd_if.valid        <= 1'b1;
          cmd_if.op           <= nxt.op;
          cmd_if.queue_number <= nxt.qn;
          cmd_if.item_tag     <= nxt.tag;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_left = 0;
      rx_cycles = 0;
    end else begin
      rx_cycles++;
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (res_if.outcome <= OUT_FULL) outcome_hits[res_if.outcome]++;
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected transaction: outcome %0d tag %h",
                     $realtime, res_if.outcome, res_if.out_tag);
        end else begin
          want = due_results.pop_front();
          if (res_if.outcome !== want.outcome || res_if.out_tag !== want.tag) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] result %0d: expected outcome %0d tag %h, got outcome %0d tag %h",
                       $realtime, results_seen, want.outcome, want.tag,
                       res_if.outcome, res_if.out_tag);
          end
        end
        // long back-pressure so the engine fills and drops cmd.ready
        if (results_seen == 150 || results_seen == 800) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case ((rx_cycles / 256) % 4)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 3) != 0);
          2: res_if.ready <= (rx_cycles % 3 == 0);
          default: res_if.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: invalid numbers, empty, extremes of tag, fill to overflow
    add_cmd(OP_ENQUEUE, 0, 16'h1234);
    add_cmd(OP_DEQUEUE, 9, 16'h0000);
    add_cmd(OP_ENQUEUE, 15, 16'hFFFF);
    add_cmd(OP_DEQUEUE, 1, 16'h0000);
    add_cmd(OP_ENQUEUE, 1, 16'hFFFF);
    add_cmd(OP_ENQUEUE, 8, 16'h0053);
    add_cmd(OP_DEQUEUE, 1, 16'hFFFF);
    add_cmd(OP_DEQUEUE, 8, 16'h0000);
    for (int i = 0; i < DEPTH + 1; i++)
      add_cmd(OP_ENQUEUE, 3, (i == 0) ? 16'h0000 : $urandom_range(0, 16'hFFFF));
    add_cmd(OP_DEQUEUE, 3, 16'h0000);
    queue_up_random(400);
    wait_drained();

    write_queue_limit(1);
    queue_up_random(200);
    wait_drained();

    write_queue_limit(15);
    queue_up_random(300);
    wait_drained();

    write_queue_limit(0);
    queue_up_random(60);
    wait_drained();

    write_queue_limit(5);
    queue_up_random(300);
    wait_drained();

    write_queue_limit(8);
    queue_up_random(240);
    wait_drained();

    repeat (10) @(posedge clk);
    if (due_results.size() != 0)
      $display("%0d expected results never arrived", due_results.size());
    $display("Covered %0d commands under queue limits 8, 1, 15, 0, 5 and 8.", cmds_taken);
    $display("Outcomes: %0d enqueued, %0d dequeued, %0d invalid, %0d empty, %0d full.",
             outcome_hits[0], outcome_hits[1], outcome_hits[2], outcome_hits[3],
             outcome_hits[4]);
    if (fail_count == 0 && due_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
